>>> rtl/mdu_pkg.sv
// Package for the multiply/divide unit: request codes and fixed widths.
// Used by the serial multiplier, the serial divider and the top level.
`timescale 1ns / 1ps

package mdu_pkg;

  // Data word width, the bit counter that walks through it and the tick counter width.
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;
  localparam int TICK_W = 6;

  // Request codes.
  localparam logic [3:0] REQ_MULT    = 4'd0;
  localparam logic [3:0] REQ_MULTU   = 4'd1;
  localparam logic [3:0] REQ_DIV     = 4'd2;
  localparam logic [3:0] REQ_DIVU    = 4'd3;
  localparam logic [3:0] REQ_READ_HI = 4'd4;
  localparam logic [3:0] REQ_READ_LO = 4'd5;
  localparam logic [3:0] REQ_WRITE_HI = 4'd6;
  localparam logic [3:0] REQ_WRITE_LO = 4'd7;
  localparam logic [3:0] REQ_TICK    = 4'd8;

  // Multiply latency classes by operand magnitude.
  localparam logic [DATA_W-1:0] MAG_SMALL  = 32'h0000_07FF;
  localparam logic [DATA_W-1:0] MAG_MEDIUM = 32'h000F_FFFF;
  localparam logic [TICK_W-1:0] TICKS_SMALL  = 6'd6;
  localparam logic [TICK_W-1:0] TICKS_MEDIUM = 6'd9;
  localparam logic [TICK_W-1:0] TICKS_LARGE  = 6'd13;

endpackage

>>> rtl/mdu_mul_serial.sv
// Bit-serial unsigned 32x32 shift-add multiplier, one multiplier bit per cycle.
// Depends on mdu_pkg for the data width.
`timescale 1ns / 1ps

module mdu_mul_serial (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [mdu_pkg::DATA_W-1:0]       mcand_in,
  input  logic [mdu_pkg::DATA_W-1:0]       mplier_in,
  output logic                             done,
  output logic [2*mdu_pkg::DATA_W-1:0]     product
);

  localparam logic [mdu_pkg::CNT_W-1:0] Last = mdu_pkg::CNT_W'(mdu_pkg::DATA_W - 1);

  logic [mdu_pkg::DATA_W-1:0] mcand;
  logic [mdu_pkg::DATA_W-1:0] hi;
  logic [mdu_pkg::DATA_W-1:0] lo;
  logic [mdu_pkg::CNT_W-1:0]  cnt;
  logic                       run;
  logic [mdu_pkg::DATA_W:0]   sum;

  // Add the multiplicand when the current multiplier bit is set.
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);

  // Shift the partial product right one bit per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand <= mcand_in;
        hi    <= '0;
        lo    <= mplier_in;
        cnt   <= '0;
        run   <= 1'b1;
      end else if (run) begin
        hi  <= sum[mdu_pkg::DATA_W:1];
        lo  <= {sum[0], lo[mdu_pkg::DATA_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == Last) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = {hi, lo};

endmodule

>>> rtl/mdu_div_serial.sv
// Bit-serial unsigned 32/32 restoring divider, one quotient bit per cycle.
// Depends on mdu_pkg for the data width.
`timescale 1ns / 1ps

module mdu_div_serial (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mdu_pkg::DATA_W-1:0]   dividend_in,
  input  logic [mdu_pkg::DATA_W-1:0]   divisor_in,
  output logic                         done,
  output logic [mdu_pkg::DATA_W-1:0]   quotient,
  output logic [mdu_pkg::DATA_W-1:0]   remainder
);

  localparam logic [mdu_pkg::CNT_W-1:0] Last = mdu_pkg::CNT_W'(mdu_pkg::DATA_W - 1);

  logic [mdu_pkg::DATA_W-1:0] dvsr;
  logic [mdu_pkg::DATA_W-1:0] rem;
  logic [mdu_pkg::DATA_W-1:0] quo;
  logic [mdu_pkg::CNT_W-1:0]  cnt;
  logic                       run;
  logic [mdu_pkg::DATA_W:0]   shifted;
  logic [mdu_pkg::DATA_W+1:0] diff;
  logic                       borrow;

  // Trial subtraction of the divisor from the partial remainder.
  // A zero divisor never borrows, which yields an all-ones quotient and
  // the dividend as remainder.
  assign shifted = {rem, quo[mdu_pkg::DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvsr};
  assign borrow  = diff[mdu_pkg::DATA_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvsr <= divisor_in;
        rem  <= '0;
        quo  <= dividend_in;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        rem <= borrow ? shifted[mdu_pkg::DATA_W-1:0] : diff[mdu_pkg::DATA_W-1:0];
        quo <= {quo[mdu_pkg::DATA_W-2:0], ~borrow};
        cnt <= cnt + 1'b1;
        if (cnt == Last) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> rtl/mips_mult_div_unit.sv
// Multiply/divide unit with HI/LO registers and a tick-driven commit countdown.
// Reads, writes, ticks and unused codes: result registered in the cycle after the transfer, busy stays low.
// Multiply and divide: the result follows the 32 steps of the bit-serial multiplier or
// divider; busy stays high until the result is given.
// Synchronous active-high reset clears HI, LO, the pending result and the countdown.
`timescale 1ns / 1ps

module mips_mult_div_unit #(
  parameter int DIV_CYCLES = 36
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   req_type,
  input  logic [mdu_pkg::DATA_W-1:0]   operand_a,
  input  logic [mdu_pkg::DATA_W-1:0]   operand_b,
  output logic                         done,
  output logic [mdu_pkg::DATA_W-1:0]   read_data,
  output logic                         stalled,
  output logic [mdu_pkg::TICK_W-1:0]   wait_ticks,
  output logic                         busy_res
);

  localparam logic [mdu_pkg::TICK_W-1:0] DivTicks = mdu_pkg::TICK_W'(DIV_CYCLES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0] state;

  logic [mdu_pkg::DATA_W-1:0] hi_reg;
  logic [mdu_pkg::DATA_W-1:0] lo_reg;
  logic [mdu_pkg::DATA_W-1:0] hi_pending;
  logic [mdu_pkg::DATA_W-1:0] lo_pending;
  logic [mdu_pkg::TICK_W-1:0] ticks_left;
  logic                       pending_valid;

  logic [mdu_pkg::TICK_W-1:0] op_ticks;
  logic                       neg_prod;
  logic                       neg_quo;
  logic                       neg_rem;

  logic                       accept;
  logic                       is_signed;
  logic                       a_neg;
  logic                       b_neg;
  logic [mdu_pkg::DATA_W-1:0] a_mag;
  logic [mdu_pkg::DATA_W-1:0] b_mag;
  logic [mdu_pkg::TICK_W-1:0] mul_ticks;
  logic                       mul_start;
  logic                       div_start;

  logic                         mul_done;
  logic [2*mdu_pkg::DATA_W-1:0] product;
  logic [2*mdu_pkg::DATA_W-1:0] product_fix;
  logic                         div_done;
  logic [mdu_pkg::DATA_W-1:0]   quotient;
  logic [mdu_pkg::DATA_W-1:0]   remainder;
  logic [mdu_pkg::DATA_W-1:0]   quo_fix;
  logic [mdu_pkg::DATA_W-1:0]   rem_fix;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Operand magnitudes; the units work on unsigned values only.
  assign is_signed = (req_type == mdu_pkg::REQ_MULT) || (req_type == mdu_pkg::REQ_DIV);
  assign a_neg     = is_signed && operand_a[mdu_pkg::DATA_W-1];
  assign b_neg     = is_signed && operand_b[mdu_pkg::DATA_W-1];
  assign a_mag     = a_neg ? (~operand_a + 1'b1) : operand_a;
  assign b_mag     = b_neg ? (~operand_b + 1'b1) : operand_b;

  // Multiply latency class from the magnitude of the multiplicand.
  always_comb begin
    if (a_mag <= mdu_pkg::MAG_SMALL) begin
      mul_ticks = mdu_pkg::TICKS_SMALL;
    end else if (a_mag <= mdu_pkg::MAG_MEDIUM) begin
      mul_ticks = mdu_pkg::TICKS_MEDIUM;
    end else begin
      mul_ticks = mdu_pkg::TICKS_LARGE;
    end
  end

  assign mul_start = accept &&
                     ((req_type == mdu_pkg::REQ_MULT) || (req_type == mdu_pkg::REQ_MULTU));
  assign div_start = accept &&
                     ((req_type == mdu_pkg::REQ_DIV) || (req_type == mdu_pkg::REQ_DIVU));

  mdu_mul_serial u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (a_mag),
    .mplier_in (b_mag),
    .done      (mul_done),
    .product   (product)
  );

  mdu_div_serial u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend_in (a_mag),
    .divisor_in  (b_mag),
    .done        (div_done),
    .quotient    (quotient),
    .remainder   (remainder)
  );

  // Sign correction of the unsigned results.
  assign product_fix = neg_prod ? (~product + 1'b1) : product;
  assign quo_fix     = neg_quo ? (~quotient + 1'b1) : quotient;
  assign rem_fix     = neg_rem ? (~remainder + 1'b1) : remainder;

  // Request handling, commit countdown and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      hi_reg        <= '0;
      lo_reg        <= '0;
      hi_pending    <= '0;
      lo_pending    <= '0;
      ticks_left    <= '0;
      pending_valid <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            read_data  <= '0;
            stalled    <= 1'b0;
            wait_ticks <= '0;
            busy_res   <= pending_valid;
            case (req_type)
              mdu_pkg::REQ_MULT, mdu_pkg::REQ_MULTU: begin
                state    <= ST_MUL;
                op_ticks <= mul_ticks;
                neg_prod <= a_neg ^ b_neg;
              end
              mdu_pkg::REQ_DIV, mdu_pkg::REQ_DIVU: begin
                state    <= ST_DIV;
                op_ticks <= DivTicks;
                neg_quo  <= a_neg ^ b_neg;
                neg_rem  <= a_neg;
              end
              mdu_pkg::REQ_READ_HI, mdu_pkg::REQ_READ_LO,
              mdu_pkg::REQ_WRITE_HI, mdu_pkg::REQ_WRITE_LO: begin
                done <= 1'b1;
                if (pending_valid) begin
                  stalled    <= 1'b1;
                  wait_ticks <= ticks_left;
                end else if (req_type == mdu_pkg::REQ_READ_HI) begin
                  read_data <= hi_reg;
                end else if (req_type == mdu_pkg::REQ_READ_LO) begin
                  read_data <= lo_reg;
                end else if (req_type == mdu_pkg::REQ_WRITE_HI) begin
                  hi_reg <= operand_a;
                end else begin
                  lo_reg <= operand_a;
                end
              end
              mdu_pkg::REQ_TICK: begin
                done <= 1'b1;
                if (pending_valid) begin
                  if (ticks_left <= 6'd1) begin
                    ticks_left    <= '0;
                    pending_valid <= 1'b0;
                    busy_res      <= 1'b0;
                    hi_reg        <= hi_pending;
                    lo_reg        <= lo_pending;
                  end else begin
                    ticks_left <= ticks_left - 1'b1;
                  end
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state         <= ST_IDLE;
            hi_pending    <= product_fix[2*mdu_pkg::DATA_W-1:mdu_pkg::DATA_W];
            lo_pending    <= product_fix[mdu_pkg::DATA_W-1:0];
            ticks_left    <= op_ticks;
            pending_valid <= 1'b1;
            busy_res      <= 1'b1;
            done          <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state         <= ST_IDLE;
            hi_pending    <= rem_fix;
            lo_pending    <= quo_fix;
            ticks_left    <= op_ticks;
            pending_valid <= 1'b1;
            busy_res      <= 1'b1;
            done          <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> dv/mips_mult_div_unit_checker.sv
// Checker for the multiply/divide unit: watches request and result transfers,
// predicts every result and compares it field by field. Depends on mdu_pkg.
`timescale 1ns / 1ps

module mips_mult_div_unit_checker #(
  parameter int DIV_CYCLES = 36
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [3:0]                   req_type,
  input  logic [mdu_pkg::DATA_W-1:0]   operand_a,
  input  logic [mdu_pkg::DATA_W-1:0]   operand_b,
  input  logic                         done,
  input  logic [mdu_pkg::DATA_W-1:0]   read_data,
  input  logic                         stalled,
  input  logic [mdu_pkg::TICK_W-1:0]   wait_ticks,
  input  logic                         busy_res,
  output int                           fail_count,
  output int                           outstanding
);

  typedef struct packed {
    logic [mdu_pkg::DATA_W-1:0] read_data;
    logic                       stalled;
    logic [mdu_pkg::TICK_W-1:0] wait_ticks;
    logic                       busy_res;
  } mdu_result_t;

  // Model copy of the architectural and pending state.
  logic [mdu_pkg::DATA_W-1:0] hi_q;
  logic [mdu_pkg::DATA_W-1:0] lo_q;
  logic [mdu_pkg::DATA_W-1:0] hi_pend;
  logic [mdu_pkg::DATA_W-1:0] lo_pend;
  logic [mdu_pkg::TICK_W-1:0] ticks_q;
  logic                       pend_valid;

  mdu_result_t expected_results[$];

  // Latency class of a multiply, by operand magnitude.
  function automatic logic [mdu_pkg::TICK_W-1:0] mult_ticks(
      input logic [mdu_pkg::DATA_W-1:0] mag);
    if (mag <= mdu_pkg::MAG_SMALL) begin
      return mdu_pkg::TICKS_SMALL;
    end
    if (mag <= mdu_pkg::MAG_MEDIUM) begin
      return mdu_pkg::TICKS_MEDIUM;
    end
    return mdu_pkg::TICKS_LARGE;
  endfunction

  task automatic load_pending(input logic [mdu_pkg::DATA_W-1:0] lo,
                              input logic [mdu_pkg::DATA_W-1:0] hi,
                              input logic [mdu_pkg::TICK_W-1:0] ticks);
    lo_pend    = lo;
    hi_pend    = hi;
    ticks_q    = ticks;
    pend_valid = 1'b1;
  endtask

  // Applies one request to the model state and returns the result it produces.
  task automatic predict_request(input logic [3:0] req, input logic [mdu_pkg::DATA_W-1:0] a,
                                 input logic [mdu_pkg::DATA_W-1:0] b,
                                 output mdu_result_t res);
    logic [63:0]                product;
    logic [mdu_pkg::DATA_W-1:0] mag_a;
    logic [mdu_pkg::DATA_W-1:0] mag_b;
    logic [mdu_pkg::DATA_W-1:0] quot;
    logic [mdu_pkg::DATA_W-1:0] rem;
    logic [mdu_pkg::TICK_W-1:0] div_ticks;
    div_ticks = mdu_pkg::TICK_W'(DIV_CYCLES);
    res = '0;
    case (req)
      mdu_pkg::REQ_MULT: begin
        product = {{32{a[31]}}, a} * {{32{b[31]}}, b};
        mag_a   = a[31] ? -a : a;
        load_pending(product[31:0], product[63:32], mult_ticks(mag_a));
      end
      mdu_pkg::REQ_MULTU: begin
        product = {32'b0, a} * {32'b0, b};
        load_pending(product[31:0], product[63:32], mult_ticks(a));
      end
      mdu_pkg::REQ_DIV: begin
        if (b == '0) begin
          load_pending(a[31] ? 32'h0000_0001 : 32'hFFFF_FFFF, a, div_ticks);
        end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
          // Signed overflow keeps the most negative quotient.
          load_pending(32'h8000_0000, '0, div_ticks);
        end else begin
          mag_a = a[31] ? -a : a;
          mag_b = b[31] ? -b : b;
          quot  = mag_a / mag_b;
          rem   = mag_a % mag_b;
          if (a[31] != b[31]) begin
            quot = -quot;
          end
          if (a[31]) begin
            rem = -rem;
          end
          load_pending(quot, rem, div_ticks);
        end
      end
      mdu_pkg::REQ_DIVU: begin
        if (b == '0) begin
          load_pending(32'hFFFF_FFFF, a, div_ticks);
        end else begin
          load_pending(a / b, a % b, div_ticks);
        end
      end
      mdu_pkg::REQ_READ_HI, mdu_pkg::REQ_READ_LO,
      mdu_pkg::REQ_WRITE_HI, mdu_pkg::REQ_WRITE_LO: begin
        // HI/LO accesses have no effect while a result is pending.
        if (pend_valid) begin
          res.stalled    = 1'b1;
          res.wait_ticks = ticks_q;
        end else if (req == mdu_pkg::REQ_READ_HI) begin
          res.read_data = hi_q;
        end else if (req == mdu_pkg::REQ_READ_LO) begin
          res.read_data = lo_q;
        end else if (req == mdu_pkg::REQ_WRITE_HI) begin
          hi_q = a;
        end else begin
          lo_q = a;
        end
      end
      mdu_pkg::REQ_TICK: begin
        if (pend_valid) begin
          if (ticks_q <= 1) begin
            ticks_q    = '0;
            pend_valid = 1'b0;
            hi_q       = hi_pend;
            lo_q       = lo_pend;
          end else begin
            ticks_q = ticks_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.busy_res = pend_valid;
  endtask

  // Compare each result transfer with the oldest expectation, then record a new request.
  always @(posedge clk) begin
    mdu_result_t got;
    mdu_result_t want;
    mdu_result_t pred;
    if (rst) begin
      hi_q       = '0;
      lo_q       = '0;
      hi_pend    = '0;
      lo_pend    = '0;
      ticks_q    = '0;
      pend_valid = 1'b0;
      expected_results.delete();
    end else begin
      if (done) begin
        got.read_data  = read_data;
        got.stalled    = stalled;
        got.wait_ticks = wait_ticks;
        got.busy_res   = busy_res;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h, actual %h", $time, want.read_data,
                     got.read_data);
            fail_count++;
          end
          if (got.stalled !== want.stalled) begin
            $display("%0t: stalled expected %b, actual %b", $time, want.stalled, got.stalled);
            fail_count++;
          end
          if (got.wait_ticks !== want.wait_ticks) begin
            $display("%0t: wait_ticks expected %0d, actual %0d", $time, want.wait_ticks,
                     got.wait_ticks);
            fail_count++;
          end
          if (got.busy_res !== want.busy_res) begin
            $display("%0t: busy_res expected %b, actual %b", $time, want.busy_res,
                     got.busy_res);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        predict_request(req_type, operand_a, operand_b, pred);
        expected_results.push_back(pred);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

>>> dv/mips_mult_div_unit_tb.sv
// Testbench top for the multiply/divide unit: clock, reset, request stimulus and verdict.
// Depends on mdu_pkg, mips_mult_div_unit and mips_mult_div_unit_checker.
`timescale 1ns / 1ps

module mips_mult_div_unit_tb;

  localparam int DIV_CYCLES    = 36;
  localparam int TARGET_ITEMS  = 1350;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam logic [3:0] REQ_CODE_MAX = 4'hF;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [3:0]                 req_type = mdu_pkg::REQ_TICK;
  logic [mdu_pkg::DATA_W-1:0] operand_a = '0;
  logic [mdu_pkg::DATA_W-1:0] operand_b = '0;
  logic                       done;
  logic [mdu_pkg::DATA_W-1:0] read_data;
  logic                       stalled;
  logic [mdu_pkg::TICK_W-1:0] wait_ticks;
  logic                       busy_res;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int items_sent = 0;
  bit quiet_stretch = 1'b0;

  mips_mult_div_unit #(
    .DIV_CYCLES(DIV_CYCLES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .done(done),
    .read_data(read_data),
    .stalled(stalled),
    .wait_ticks(wait_ticks),
    .busy_res(busy_res)
  );

  mips_mult_div_unit_checker #(
    .DIV_CYCLES(DIV_CYCLES)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .done(done),
    .read_data(read_data),
    .stalled(stalled),
    .wait_ticks(wait_ticks),
    .busy_res(busy_res),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the unit hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one request after a random gap and hold it until the transfer.
  task automatic send_request(input logic [3:0] req, input logic [mdu_pkg::DATA_W-1:0] a,
                              input logic [mdu_pkg::DATA_W-1:0] b);
    int gap;
    gap = quiet_stretch ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    req_type  <= req;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_request(mdu_pkg::REQ_TICK, $urandom(), $urandom());
  endtask

  // Operand values weighted toward sign, overflow and latency-class boundaries.
  function automatic logic [mdu_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return mdu_pkg::MAG_SMALL + $urandom_range(0, 1);
      5: return mdu_pkg::MAG_MEDIUM + $urandom_range(0, 1);
      6: return $urandom_range(0, mdu_pkg::MAG_SMALL);
      7: return -$urandom_range(0, mdu_pkg::MAG_SMALL + 1);
      8: return $urandom_range(0, mdu_pkg::MAG_MEDIUM + 1);
      9: return -$urandom_range(0, mdu_pkg::MAG_MEDIUM + 1);
      default: return $urandom();
    endcase
  endfunction

  // Start one or more operations, tick toward the commit with some accesses mixed in,
  // then read both result registers.
  task automatic run_operation();
    logic [3:0] op;
    int         n_ops;
    int         n_ticks;
    n_ops = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
    repeat (n_ops) begin
      op = ($urandom_range(0, 2) == 0)
           ? 4'($urandom_range(mdu_pkg::REQ_DIV, mdu_pkg::REQ_DIVU))
           : 4'($urandom_range(mdu_pkg::REQ_MULT, mdu_pkg::REQ_MULTU));
      send_request(op, pick_word(), pick_word());
    end
    if (op == mdu_pkg::REQ_DIV || op == mdu_pkg::REQ_DIVU) begin
      n_ticks = ($urandom_range(0, 3) != 0) ? DIV_CYCLES : $urandom_range(0, DIV_CYCLES);
    end else begin
      n_ticks = ($urandom_range(0, 3) != 0) ? int'(mdu_pkg::TICKS_LARGE)
                                            : $urandom_range(0, mdu_pkg::TICKS_LARGE);
    end
    repeat (n_ticks) begin
      if ($urandom_range(0, 7) == 0) begin
        send_request(4'($urandom_range(mdu_pkg::REQ_READ_HI, mdu_pkg::REQ_WRITE_LO)),
                     pick_word(), pick_word());
      end
      send_request(mdu_pkg::REQ_TICK, $urandom(), $urandom());
    end
    send_request(mdu_pkg::REQ_READ_HI, $urandom(), $urandom());
    send_request(mdu_pkg::REQ_READ_LO, $urandom(), $urandom());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle tick, unused code, register extremes, stalls, replacement,
    // divide by zero, signed overflow and the commit of a short multiply.
    send_request(mdu_pkg::REQ_TICK, '0, '0);
    send_request(REQ_CODE_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(mdu_pkg::REQ_WRITE_HI, 32'hFFFF_FFFF, '0);
    send_request(mdu_pkg::REQ_WRITE_LO, '0, 32'hFFFF_FFFF);
    send_request(mdu_pkg::REQ_READ_HI, '0, '0);
    send_request(mdu_pkg::REQ_READ_LO, '0, '0);
    send_request(mdu_pkg::REQ_MULT, 32'h8000_0000, 32'h8000_0000);
    send_request(mdu_pkg::REQ_READ_HI, '0, '0);
    send_request(mdu_pkg::REQ_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(mdu_pkg::REQ_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(mdu_pkg::REQ_DIV, 32'hFFFF_FFF9, '0);
    send_request(mdu_pkg::REQ_DIVU, 32'd5, '0);
    send_request(mdu_pkg::REQ_DIV, 32'd7, '0);
    send_request(mdu_pkg::REQ_DIV, 32'hFFFF_FFF9, 32'd2);
    send_request(mdu_pkg::REQ_MULT, 32'h0000_07FF, 32'hFFFF_FFFD);
    send_request(mdu_pkg::REQ_WRITE_LO, 32'h1234_5678, '0);
    send_ticks(int'(mdu_pkg::TICKS_SMALL));
    send_request(mdu_pkg::REQ_READ_HI, '0, '0);
    send_request(mdu_pkg::REQ_READ_LO, '0, '0);

    // Random: mostly complete operation sequences, the rest loose accesses and noise.
    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        quiet_stretch = !quiet_stretch;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: run_operation();
        6, 7: send_request(4'($urandom_range(mdu_pkg::REQ_READ_HI, mdu_pkg::REQ_WRITE_LO)),
                           pick_word(), pick_word());
        8: send_request(4'($urandom_range(0, REQ_CODE_MAX)), $urandom(), $urandom());
        default: send_request(4'($urandom_range(mdu_pkg::REQ_TICK + 1, REQ_CODE_MAX)),
                              pick_word(), pick_word());
      endcase
    end
    start <= 1'b0;

    // Drain outstanding results, then allow the unit's latency to pass.
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
